### sv/stpprof_pkg.sv
// shared types and constants for the trapezoid motion profile core
package stpprof_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int VEL_W      = 18;
    localparam int VX_W       = 22;
    localparam int MS_W       = 17;
    localparam int ACC_W      = 9;
    localparam int IDLE_W     = 16;
    localparam int CFG_W      = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int QUO_W      = 2 * VEL_W - 1;
    localparam int CNT_W      = $clog2(QUO_W + 1);
    localparam int DIVR_W     = ACC_W + 1;
    localparam int S_DATA_W   = 32;
    localparam int S_USER_W   = 2;
    localparam int M_DATA_W   = 88;

    localparam logic signed [VX_W-1:0] VEL_MAX = VX_W'(131071);
    localparam logic signed [VX_W-1:0] VEL_MIN = -VX_W'(131072);
    localparam logic [IDLE_W-1:0]      IDLE_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPEED_LIMIT = 2'd0,
        CFG_ACCEL       = 2'd1,
        CFG_SLEEP_DELAY = 2'd2,
        CFG_NONE        = 2'd3
    } t_cfg_idx;

    typedef enum logic [S_USER_W-1:0] {
        ACT_TICK   = 2'd0,
        ACT_SET    = 2'd1,
        ACT_MOVE   = 2'd2,
        ACT_FORGET = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_EXEC = 3'b100
    } t_state;

    function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [VX_W-1:0] v);
        logic signed [VX_W-1:0] r;
        begin
            r = v;
            if (v > VEL_MAX) r = VEL_MAX;
            if (v < VEL_MIN) r = VEL_MIN;
            return r[VEL_W-1:0];
        end
    endfunction

endpackage

### sv/stepper_trapezoid_motion_profile_core.sv
// trapezoidal velocity profile stepper controller with bit-serial decel threshold divider
// order: a tick goes from idle through the divider state to the update state, other
//   actions go straight to the update, which waits until the output register is free; no
//   new transaction is taken before that; the divider retires one quotient bit per cycle
// reset: synchronous active-low, back to asleep, position unknown, speed limit 1,
//   accel 1, sleep delay 1000
module stepper_trapezoid_motion_profile_core #(
    parameter int POS_WIDTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [stpprof_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [stpprof_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // position_value
    input  logic [stpprof_pkg::S_DATA_W-1:0]     s_axis_tdata,
    // action
    input  logic [stpprof_pkg::S_USER_W-1:0]     s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // step_pulse, step_forward, asleep, position_known, motor_pos_out[31:0],
    // target_out[31:0], velocity_out[17:0], zero pad[1:0]
    output logic [stpprof_pkg::M_DATA_W-1:0]     m_axis_tdata
);
    import stpprof_pkg::*;

    localparam int PW = POS_WIDTH;
    localparam int XW = (PW > 32) ? PW : 32;
    localparam int DW = PW + 1;
    localparam int CW = (DW > QUO_W) ? DW : QUO_W;
    localparam logic [PW-1:0]  ONE_P = PW'(64'd1 << FRAC_BITS);
    localparam logic [21:0]    ONE_C = 22'(64'd1 << FRAC_BITS);
    localparam logic [QUO_W-1:0] FRAC_MASK = ~QUO_W'((64'd1 << FRAC_BITS) - 64'd1);

    t_state                    r_state;
    t_action                   r_act;
    logic signed [PW-1:0]      r_pos;
    logic [MS_W-1:0]           r_max;
    logic [ACC_W-1:0]          r_accel;
    logic [IDLE_W-1:0]         r_delay;
    logic                      r_fwd, n_fwd;
    logic signed [VEL_W-1:0]   r_spd, n_spd;
    logic signed [PW-1:0]      r_prof, n_prof;
    logic signed [PW-1:0]      r_step, n_step;
    logic signed [PW-1:0]      r_goal, n_goal;
    logic [IDLE_W-1:0]         r_idle, n_idle;
    logic                      r_sleep, n_sleep;
    logic                      r_known, n_known;
    logic                      n_pulse;
    logic [QUO_W-1:0]          r_quo;
    logic [DIVR_W-1:0]         r_rem;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_mvalid;
    logic [M_DATA_W-1:0]       r_mdata;

    // input position and config clamps
    logic signed [XW-1:0]      in_ext;
    logic [21:0]               ms_raw;
    logic [MS_W-1:0]           ms_clamp;
    logic [ACC_W-1:0]          acc_clamp;

    always_comb begin
        in_ext    = XW'(signed'(s_axis_tdata));
        ms_raw    = 22'(i_cfg_data[MS_W-1:0]);
        ms_clamp  = i_cfg_data[MS_W-1:0];
        if (ms_raw == 22'd0) ms_clamp = MS_W'(1);
        if (ms_raw > ONE_C)  ms_clamp = MS_W'(ONE_C);
        acc_clamp = i_cfg_data[ACC_W-1:0];
        if (acc_clamp == '0)                  acc_clamp = ACC_W'(1);
        if (acc_clamp > ACC_W'(256))          acc_clamp = ACC_W'(256);
    end

    // divider step
    logic [DIVR_W-1:0]         divisor;
    logic [DIVR_W:0]           rem_sh;
    logic                      qbit;
    logic [DIVR_W-1:0]         rem_nx;
    logic signed [2*VEL_W-1:0] sq_s;
    logic [2*VEL_W-1:0]        sq_full;
    logic [QUO_W-1:0]          dividend;

    always_comb begin
        divisor  = {r_accel, 1'b0};
        rem_sh   = {r_rem, r_quo[QUO_W-1]};
        qbit     = rem_sh >= {1'b0, divisor};
        rem_nx   = qbit ? DIVR_W'(rem_sh - {1'b0, divisor}) : rem_sh[DIVR_W-1:0];
        sq_s     = (2*VEL_W)'(r_spd) * (2*VEL_W)'(r_spd);
        sq_full  = unsigned'(sq_s);
        dividend = sq_full[QUO_W-1:0] & FRAC_MASK;
    end

    // profile update
    logic signed [DW-1:0]    diff;
    logic [DW-1:0]           absd;
    logic                    near;
    logic                    skip;
    logic signed [VX_W-1:0]  spd_x, acc_x, top_x, v_x;
    logic signed [PW-1:0]    prof_nx;
    logic signed [XW-1:0]    step_o, goal_o;

    always_comb begin
        diff   = DW'(r_goal) - DW'(r_prof);
        absd   = diff[DW-1] ? DW'(-diff) : DW'(diff);
        near   = CW'(absd) <= CW'(r_quo);
        spd_x  = VX_W'(r_spd);
        acc_x  = signed'(VX_W'(r_accel));
        top_x  = signed'(VX_W'(r_max));
        v_x    = '0;
        prof_nx = '0;
        skip   = 1'b0;
        n_fwd   = r_fwd;
        n_spd   = r_spd;
        n_prof  = r_prof;
        n_step  = r_step;
        n_goal  = r_goal;
        n_idle  = r_idle;
        n_sleep = r_sleep;
        n_known = r_known;
        n_pulse = 1'b0;
        case (r_act)
            ACT_TICK: begin
                if (r_step != r_goal) begin
                    n_idle = '0;
                end else if (r_sleep) begin
                    skip = 1'b1;
                end else if (r_idle > r_delay) begin
                    n_sleep = 1'b1;
                    n_idle  = '0;
                    skip    = 1'b1;
                end else if (r_idle != IDLE_MAX) begin
                    n_idle = r_idle + 1'b1;
                end
                if (!skip) begin
                    if (r_fwd) begin
                        if (r_prof > r_goal || near) begin
                            n_spd = sat_vel(spd_x - acc_x);
                        end else if (r_prof < r_goal) begin
                            v_x   = spd_x + acc_x;
                            n_spd = sat_vel((v_x < top_x) ? v_x : top_x);
                        end
                        prof_nx = r_prof + PW'(n_spd);
                        if (r_step < prof_nx && r_step != r_goal) begin
                            n_step  = r_step + ONE_P;
                            n_pulse = 1'b1;
                        end
                        if (n_spd < 0) n_fwd = 1'b0;
                    end else begin
                        if (r_prof < r_goal || near) begin
                            n_spd = sat_vel(spd_x + acc_x);
                        end else if (r_prof > r_goal) begin
                            v_x   = spd_x - acc_x;
                            n_spd = sat_vel((v_x > -top_x) ? v_x : -top_x);
                        end
                        prof_nx = r_prof + PW'(n_spd);
                        if (r_step > prof_nx && r_step != r_goal) begin
                            n_step  = r_step - ONE_P;
                            n_pulse = 1'b1;
                        end
                        if (n_spd > 0) n_fwd = 1'b1;
                    end
                    n_prof = prof_nx;
                end
            end
            ACT_SET: begin
                n_step  = r_pos;
                n_prof  = r_pos;
                n_goal  = r_pos;
                n_known = 1'b1;
            end
            ACT_MOVE: begin
                if (r_pos != r_goal) begin
                    n_sleep = 1'b0;
                    n_idle  = '0;
                end
                n_goal = r_pos;
            end
            ACT_FORGET: begin
                n_known = 1'b0;
            end
            default: begin
                n_known = r_known;
            end
        endcase
        step_o = XW'(n_step);
        goal_o = XW'(n_goal);
    end

    logic out_free;
    assign out_free      = !r_mvalid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_act    <= ACT_TICK;
            r_mvalid <= 1'b0;
            r_max    <= MS_W'(1);
            r_accel  <= ACC_W'(1);
            r_delay  <= IDLE_W'(1000);
            r_fwd    <= 1'b1;
            r_spd    <= '0;
            r_prof   <= '0;
            r_step   <= '0;
            r_goal   <= '0;
            r_idle   <= '0;
            r_sleep  <= 1'b1;
            r_known  <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_SPEED_LIMIT: r_max   <= ms_clamp;
                    CFG_ACCEL:       r_accel <= acc_clamp;
                    CFG_SLEEP_DELAY: r_delay <= i_cfg_data[IDLE_W-1:0];
                    default:         r_delay <= r_delay;
                endcase
            end
            if (r_mvalid && m_axis_tready && r_state != ST_EXEC) begin
                r_mvalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_act <= t_action'(s_axis_tuser);
                        r_pos <= in_ext[PW-1:0];
                        if (t_action'(s_axis_tuser) == ACT_TICK) begin
                            r_quo   <= dividend;
                            r_rem   <= '0;
                            r_cnt   <= CNT_W'(QUO_W);
                            r_state <= ST_DIV;
                        end else begin
                            r_state <= ST_EXEC;
                        end
                    end
                end
                ST_DIV: begin
                    r_rem <= rem_nx;
                    r_quo <= {r_quo[QUO_W-2:0], qbit};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (out_free) begin
                        r_fwd    <= n_fwd;
                        r_spd    <= n_spd;
                        r_prof   <= n_prof;
                        r_step   <= n_step;
                        r_goal   <= n_goal;
                        r_idle   <= n_idle;
                        r_sleep  <= n_sleep;
                        r_known  <= n_known;
                        r_mvalid <= 1'b1;
                        r_mdata  <= {2'b00, n_spd, goal_o[31:0], step_o[31:0],
                                     n_known, n_sleep, n_fwd, n_pulse};
                        r_state  <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
